/* design/gtf_pkg.sv */
`timescale 1ns / 1ps
package gtf_pkg;

  localparam int ELEM_W      = 12;
  localparam int TEAM_ID_W   = 6;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;

  localparam int DEF_ELEMENTS = 4096;
  localparam int DEF_TEAMS    = 64;
  localparam int DEF_CAPACITY = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_ASSIGN  = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_DEQUEUE = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 3'd0,
    ST_DEQUEUED   = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_FULL       = 3'd3,
    ST_UNASSIGNED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ASSIGN,
    S_ENQ_LOOK,
    S_ENQ_TAKE,
    S_ENQ_LINK,
    S_DEQ_CHECK,
    S_DEQ_TEAM,
    S_DEQ_SLOT,
    S_DEQ_DONE,
    S_CLEAR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    assign_wr;
    logic    enq_take;
    logic    enq_link;
    logic    deq_team;
    logic    deq_slot;
    logic    deq_done;
    logic    sweep_step;
    logic    res_load;
    status_t res_code;
    logic    load_out;
  } gtf_cmd_t;

  typedef struct packed {
    logic enq_unassigned;
    logic enq_full;
    logic team_busy;
    logic order_empty;
    logic sweep_last;
    logic out_busy;
  } gtf_sts_t;

endpackage

/* design/gtf_ctrl.sv */
`timescale 1ns / 1ps
module gtf_ctrl import gtf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  opcode_t  op,
  input  gtf_sts_t sts,
  output logic     in_stall,
  output gtf_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_code = ST_DONE;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          unique case (op)
            OP_ASSIGN:  state_next = S_ASSIGN;
            OP_ENQUEUE: state_next = S_ENQ_LOOK;
            OP_DEQUEUE: state_next = S_DEQ_CHECK;
            OP_CLEAR:   state_next = S_CLEAR;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ASSIGN: begin
        cmd.assign_wr = 1'b1;
        cmd.res_load  = 1'b1;
        state_next    = S_OUT;
      end
      S_ENQ_LOOK: state_next = S_ENQ_TAKE;
      S_ENQ_TAKE: begin
        cmd.enq_take = 1'b1;
        cmd.res_load = 1'b1;
        priority if (sts.enq_unassigned) begin
          cmd.res_code = ST_UNASSIGNED;
          state_next   = S_OUT;
        end else if (sts.enq_full) begin
          cmd.res_code = ST_FULL;
          state_next   = S_OUT;
        end else if (sts.team_busy) begin
          state_next = S_ENQ_LINK;
        end else begin
          state_next = S_OUT;
        end
      end
      S_ENQ_LINK: begin
        cmd.enq_link = 1'b1;
        state_next   = S_OUT;
      end
      S_DEQ_CHECK: begin
        if (sts.order_empty) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_EMPTY;
          state_next   = S_OUT;
        end else begin
          state_next = S_DEQ_TEAM;
        end
      end
      S_DEQ_TEAM: begin
        cmd.deq_team = 1'b1;
        state_next   = S_DEQ_SLOT;
      end
      S_DEQ_SLOT: begin
        cmd.deq_slot = 1'b1;
        state_next   = S_DEQ_DONE;
      end
      S_DEQ_DONE: begin
        cmd.deq_done = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_DEQUEUED;
        state_next   = S_OUT;
      end
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.res_load = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

/* design/gtf_datapath.sv */
`timescale 1ns / 1ps
module gtf_datapath import gtf_pkg::*; #(
  parameter int ELEMENTS = DEF_ELEMENTS,
  parameter int TEAMS    = DEF_TEAMS,
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst,
  input  gtf_cmd_t            cmd,
  input  logic [ELEM_W-1:0]   element_id,
  input  logic [TEAM_ID_W-1:0] team_id,
  input  logic                out_stall,
  output gtf_sts_t            sts,
  output logic                out_valid,
  output logic [ELEM_W-1:0]   dequeued_element,
  output logic [STATUS_W-1:0] status
);

  localparam int EW  = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int CW  = $clog2(CAPACITY);
  localparam int FW  = $clog2(CAPACITY + 1);
  localparam int TW  = (TEAMS > 1) ? $clog2(TEAMS) : 1;
  localparam int OW  = $clog2(TEAMS + 1);
  localparam int MW  = $clog2(TEAMS + 1);
  localparam int NS  = (ELEMENTS > CAPACITY) ? ELEMENTS : CAPACITY;
  localparam int NW  = $clog2(NS);

  // storage
  logic [MW-1:0]     membership   [ELEMENTS];
  logic [ELEM_W-1:0] slot_element [CAPACITY];
  logic [CW-1:0]     slot_next    [CAPACITY];
  logic [CW-1:0]     team_head    [TEAMS];
  logic [CW-1:0]     team_tail    [TEAMS];
  logic [TW-1:0]     order_ring   [TEAMS];
  logic [TEAMS-1:0]  team_nonempty;

  // control registers
  logic [CW-1:0] free_head;
  logic [FW-1:0] free_count;
  logic [TW-1:0] order_read_ptr, order_write_ptr;
  logic [OW-1:0] order_count;
  logic [NW-1:0] sweep_cnt;

  // item registers
  logic [ELEM_W-1:0] elem_r;
  logic [TEAM_ID_W-1:0] team_r;
  logic              elem_ok_r, assign_ok_r;
  logic [TW-1:0]     t_r;
  logic [CW-1:0]     slot_r;
  logic              last_r;
  logic [ELEM_W-1:0] res_elem;
  status_t           res_status;

  // registered read data
  logic [MW-1:0]     mem_rd;
  logic [CW-1:0]     snext_rd, head_rd, tail_rd;
  logic [ELEM_W-1:0] selem_rd;
  logic [TW-1:0]     ring_rd;

  logic [EW-1:0] elem_idx;
  logic [TW-1:0] t_enq;
  logic [CW-1:0] snext_raddr;
  logic [TW-1:0] tail_raddr;
  logic          do_take, team_busy_enq;

  assign elem_idx      = EW'(elem_r);
  assign t_enq         = TW'(mem_rd - MW'(1));
  assign snext_raddr   = cmd.deq_slot ? head_rd : free_head;
  assign tail_raddr    = cmd.enq_take ? t_enq : ring_rd;
  assign team_busy_enq = team_nonempty[t_enq];
  assign do_take       = cmd.enq_take && !sts.enq_unassigned && !sts.enq_full;

  assign sts.enq_unassigned = !elem_ok_r || (mem_rd == '0);
  assign sts.enq_full       = (free_count == '0);
  assign sts.team_busy      = team_busy_enq;
  assign sts.order_empty    = (order_count == '0);
  assign sts.sweep_last     = (sweep_cnt == NW'(NS - 1));
  assign sts.out_busy       = out_valid && out_stall;

  function automatic logic [TW-1:0] ptr_inc(input logic [TW-1:0] p);
    ptr_inc = (p == TW'(TEAMS - 1)) ? '0 : p + TW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      elem_r      <= element_id;
      team_r      <= team_id;
      elem_ok_r   <= (32'(element_id) < ELEMENTS);
      assign_ok_r <= (32'(element_id) < ELEMENTS) && (32'(team_id) < TEAMS);
    end
    if (cmd.deq_team) t_r <= ring_rd;
    if (do_take) begin
      t_r    <= t_enq;
      slot_r <= free_head;
    end
    if (cmd.deq_slot) begin
      slot_r <= head_rd;
      last_r <= (head_rd == tail_rd);
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      res_elem   <= cmd.deq_done ? selem_rd : '0;
    end
  end

  // memory reads
  always_ff @(posedge clk) begin
    mem_rd   <= membership[elem_idx];
    snext_rd <= slot_next[snext_raddr];
    selem_rd <= slot_element[head_rd];
    head_rd  <= team_head[ring_rd];
    tail_rd  <= team_tail[tail_raddr];
    ring_rd  <= order_ring[order_read_ptr];
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      if (32'(sweep_cnt) < ELEMENTS) membership[EW'(sweep_cnt)] <= '0;
    end else if (cmd.assign_wr && assign_ok_r) begin
      membership[elem_idx] <= MW'(32'(team_r) + 1);
    end
    if (do_take) slot_element[free_head] <= elem_r;
    if (cmd.sweep_step) begin
      if (32'(sweep_cnt) < CAPACITY) begin
        slot_next[CW'(sweep_cnt)] <=
          (32'(sweep_cnt) == CAPACITY - 1) ? '0 : CW'(32'(sweep_cnt) + 1);
      end
    end else if (do_take) begin
      slot_next[free_head] <= '0;
    end else if (cmd.enq_link) begin
      slot_next[tail_rd] <= slot_r;
    end else if (cmd.deq_done) begin
      slot_next[slot_r] <= free_head;
    end
    if (do_take && !team_busy_enq) begin
      team_head[t_enq] <= free_head;
    end else if (cmd.deq_done && !last_r) begin
      team_head[t_r] <= snext_rd;
    end
    if (do_take && !team_busy_enq) begin
      team_tail[t_enq] <= free_head;
    end else if (cmd.enq_link) begin
      team_tail[t_r] <= slot_r;
    end
    if (do_take && !team_busy_enq && (32'(order_count) < TEAMS)) begin
      order_ring[order_write_ptr] <= t_enq;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_step) begin
      free_head       <= '0;
      free_count      <= FW'(CAPACITY);
      order_read_ptr  <= '0;
      order_write_ptr <= '0;
      order_count     <= '0;
      team_nonempty   <= '0;
    end else begin
      if (do_take) begin
        free_head  <= snext_rd;
        free_count <= free_count - FW'(1);
        if (!team_busy_enq) begin
          team_nonempty[t_enq] <= 1'b1;
          if (32'(order_count) < TEAMS) begin
            order_write_ptr <= ptr_inc(order_write_ptr);
            order_count     <= order_count + OW'(1);
          end
        end
      end
      if (cmd.deq_done) begin
        free_head <= slot_r;
        if (32'(free_count) < CAPACITY) free_count <= free_count + FW'(1);
        if (last_r) begin
          team_nonempty[t_r] <= 1'b0;
          order_read_ptr     <= ptr_inc(order_read_ptr);
          order_count        <= order_count - OW'(1);
        end
      end
    end
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep_step) begin
      sweep_cnt <= sts.sweep_last ? '0 : sweep_cnt + NW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      dequeued_element <= res_elem;
      status           <= res_status;
    end
  end

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    32'(free_count) <= CAPACITY) else $error("free count above capacity");
  a_order_bound: assert property (@(posedge clk) disable iff (rst)
    32'(order_count) <= TEAMS) else $error("order count above team count");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid) else $error("result not presented");
  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    do_take |-> free_count != '0) else $error("slot taken from empty pool");
`endif

endmodule

/* design/grouped_team_fifo_core.sv */
`timescale 1ns / 1ps
// Channel | Handshake           | Fields
// input   | in_valid / in_stall | opcode, element_id, team_id
// output  | out_valid/out_stall | dequeued_element, status
//
// States per item: assign ASSIGN; enqueue ENQ_LOOK, ENQ_TAKE, then ENQ_LINK if
// the team had members; dequeue DEQ_CHECK, then DEQ_TEAM, DEQ_SLOT, DEQ_DONE if
// not empty; clear sweeps in CLEAR; all end in OUT, following dependent reads.
// Reset (rst, synchronous) runs a sweep that clears membership and rebuilds
// the slot free list; no item is taken meanwhile.
// An item is taken while the previous result still waits in the output
// register; a stalled output holds the block only when its next result is due.
module grouped_team_fifo_core import gtf_pkg::*; #(
  parameter int ELEMENTS = DEF_ELEMENTS,
  parameter int TEAMS    = DEF_TEAMS,
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      opcode,
  input  logic [ELEM_W-1:0]    element_id,
  input  logic [TEAM_ID_W-1:0] team_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ELEM_W-1:0]    dequeued_element,
  output logic [STATUS_W-1:0]  status
);

  gtf_cmd_t cmd;
  gtf_sts_t sts;

  // sequencer: one item in flight, walks the linked-list steps
  gtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (opcode_t'(opcode)),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // memories, pointers, free list and output register
  gtf_datapath #(
    .ELEMENTS (ELEMENTS),
    .TEAMS    (TEAMS),
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .element_id       (element_id),
    .team_id          (team_id),
    .out_stall        (out_stall),
    .sts              (sts),
    .out_valid        (out_valid),
    .dequeued_element (dequeued_element),
    .status           (status)
  );

endmodule
